### src/snapshot_interpolation_buffer_top_assert.svh
// Assertion macros for the snapshot interpolation buffer.
`ifndef SNAPSHOT_INTERPOLATION_BUFFER_TOP_ASSERT_SVH
`define SNAPSHOT_INTERPOLATION_BUFFER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SIB_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sib assertion failed");
`define SIB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sib assertion failed");
`else
`define SIB_ASSERT(lbl, cond)
`define SIB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/sib_pkg.sv
// Shared types and constants of the snapshot interpolation buffer.
`timescale 1ns / 1ps
package sib_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH,
        S_PRUNE_RD,
        S_PRUNE_CMP,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FRAC,
        S_DIV,
        S_POSE_OLD,
        S_POSE_NEW,
        S_POSE_GET,
        S_MUL,
        S_ADD,
        S_OUT
    } sib_state_t;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_REMOTE_MODE    = 2'd0;
    localparam logic [1:0] REG_RENDER_DELAY   = 2'd1;
    localparam logic [1:0] REG_STALE_AGE      = 2'd2;
    localparam logic [1:0] REG_HISTORY_WINDOW = 2'd3;

    localparam logic [15:0] RENDER_DELAY_RST   = 16'd100;
    localparam logic [15:0] STALE_AGE_RST      = 16'd1000;
    localparam logic [15:0] HISTORY_WINDOW_RST = 16'd1000;

    localparam int         COORDS    = 6;
    localparam int         POSE_W    = 32 * COORDS;
    localparam logic [16:0] FRAC_ONE = 17'h10000;
    localparam logic [3:0] DIV_LAST  = 4'd15;
    localparam logic [2:0] COORD_LAST = 3'd5;

endpackage

### src/snapshot_interpolation_buffer_top.sv
// Snapshot interpolation buffer: ring of timed poses, pruning and interpolated queries.
`timescale 1ns / 1ps
// Throughput: one word at a time; s_tready is high only in the idle state, so a push runs
// through its prune, an interpolating query through its scan, divide and multiply steps,
// and a held result waits for m_tready before the next word is taken. The time scan (one
// time memory read port), the 16-step fraction divider and the single shared 33x18
// multiplier set how long an interpolating query takes.
// Reset: rst_n clears the ring head and count, the latest pose, the last update time and
// the registers (remote 0, delay 100, stale age 1000, window 1000); memories are not cleared.
`include "snapshot_interpolation_buffer_top_assert.svh"
module snapshot_interpolation_buffer_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata: now_ms, in_pos_x, in_pos_y, in_pos_z, in_rot_x, in_rot_y, in_rot_z
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [223:0] s_tdata,
    // s_tuser: op
    input  logic [0:0]   s_tuser,
    // m_tdata: out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,
    // m_tuser: stale, blended
    output logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import sib_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    // Slot of the k-th oldest entry; head + k stays below twice the depth.
    function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] h, input logic [IW-1:0] k);
        logic [IW:0] s;
        s = {1'b0, h} + {1'b0, k};
        if (s >= (IW+1)'(RING_DEPTH))
            s = s - (IW+1)'(RING_DEPTH);
        return s[IW-1:0];
    endfunction

    // Configuration registers.
    logic        remote_mode_reg;
    logic [15:0] render_delay_reg, stale_age_reg, history_window_reg;

    // Control state.
    sib_state_t    state_reg, state_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] k_reg, k_next;
    logic [3:0]    div_cnt_reg, div_cnt_next;
    logic [2:0]    j_reg, j_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [POSE_W-1:0] latest_pose_reg, latest_pose_next;
    logic [31:0]   last_update_reg, last_update_next;

    // Payload registers.
    logic [31:0]   now_reg, now_next;
    logic [POSE_W-1:0] in_pose_reg, in_pose_next;
    logic [31:0]   render_reg, render_next;
    logic          stale_reg, stale_next;
    logic          blended_reg, blended_next;
    logic [31:0]   prev_t_reg, prev_t_next;
    logic [31:0]   t0_reg, t0_next, t1_reg, t1_next;
    logic [31:0]   t_old_reg, t_old_next, t_new_reg, t_new_next;
    logic [IW-1:0] prev_slot_reg, prev_slot_next;
    logic [IW-1:0] older_reg, older_next, newer_reg, newer_next;
    logic [31:0]   rem_reg, rem_next;
    logic [16:0]   frac_reg, frac_next;
    logic [POSE_W-1:0] pose_old_reg, pose_old_next, pose_new_reg, pose_new_next;
    logic signed [50:0] prod_reg, prod_next;
    logic [POSE_W-1:0] res_reg, res_next;
    logic [191:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    // Time memory and pose memory, one write and one registered read port each.
    logic [31:0]     time_mem [RING_DEPTH];
    logic [POSE_W-1:0] pose_mem [RING_DEPTH];
    logic            mem_we;
    logic [IW-1:0]   mem_waddr, time_raddr, pose_raddr;
    logic [31:0]     time_q;
    logic [POSE_W-1:0] pose_q;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            time_mem[mem_waddr] <= now_reg;
            pose_mem[mem_waddr] <= in_pose_reg;
        end
        time_q <= time_mem[time_raddr];
        pose_q <= pose_mem[pose_raddr];
    end

    // APB register file; pready is always high.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remote_mode_reg    <= 1'b0;
            render_delay_reg   <= RENDER_DELAY_RST;
            stale_age_reg      <= STALE_AGE_RST;
            history_window_reg <= HISTORY_WINDOW_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_REMOTE_MODE:    remote_mode_reg    <= pwdata[0];
                REG_RENDER_DELAY:   render_delay_reg   <= pwdata[15:0];
                REG_STALE_AGE:      stale_age_reg      <= pwdata[15:0];
                REG_HISTORY_WINDOW: history_window_reg <= pwdata[15:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_REMOTE_MODE:    prdata = {31'd0, remote_mode_reg};
            REG_RENDER_DELAY:   prdata = {16'd0, render_delay_reg};
            REG_STALE_AGE:      prdata = {16'd0, stale_age_reg};
            REG_HISTORY_WINDOW: prdata = {16'd0, history_window_reg};
            default:            prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    // Working values of the sequencer.
    logic [IW-1:0]  cur_slot, push_head, push_slot;
    logic [CW-1:0]  push_count;
    logic [31:0]    now_age, last_age, span, el;
    logic [32:0]    rem_dbl;
    logic [31:0]    old_c, new_c, prod_hi;
    logic signed [32:0] diff_c;

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        div_cnt_next     = div_cnt_reg;
        j_next           = j_reg;
        m_tvalid_next    = m_tvalid_reg;
        latest_pose_next = latest_pose_reg;
        last_update_next = last_update_reg;
        now_next         = now_reg;
        in_pose_next     = in_pose_reg;
        render_next      = render_reg;
        stale_next       = stale_reg;
        blended_next     = blended_reg;
        prev_t_next      = prev_t_reg;
        t0_next          = t0_reg;
        t1_next          = t1_reg;
        t_old_next       = t_old_reg;
        t_new_next       = t_new_reg;
        prev_slot_next   = prev_slot_reg;
        older_next       = older_reg;
        newer_next       = newer_reg;
        rem_next         = rem_reg;
        frac_next        = frac_reg;
        pose_old_next    = pose_old_reg;
        pose_new_next    = pose_new_reg;
        prod_next        = prod_reg;
        res_next         = res_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        mem_we     = 1'b0;
        time_raddr = head_reg;
        pose_raddr = older_reg;

        cur_slot   = slot_of(head_reg, k_reg);
        push_head  = head_reg;
        push_count = count_reg;
        if (count_reg == DEPTH_C)
        begin
            push_head  = slot_of(head_reg, IW'(1));
            push_count = DEPTH_C - CW'(1);
        end
        push_slot = slot_of(push_head, push_count[IW-1:0]);
        mem_waddr = push_slot;

        now_age  = now_reg - time_q;
        last_age = s_tdata[31:0] - last_update_reg;
        span     = t_new_reg - t_old_reg;
        el       = render_reg - t_old_reg;
        rem_dbl  = {rem_reg, 1'b0};
        old_c    = pose_old_reg[32*j_reg +: 32];
        new_c    = pose_new_reg[32*j_reg +: 32];
        diff_c   = $signed({new_c[31], new_c}) - $signed({old_c[31], old_c});
        prod_hi  = prod_reg[47:16];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    now_next     = s_tdata[31:0];
                    in_pose_next = s_tdata[223:32];
                    render_next  = s_tdata[31:0] - {16'd0, render_delay_reg};
                    stale_next   = $signed(last_age) > $signed({16'd0, stale_age_reg});
                    if (s_tuser[0] == OP_PUSH)
                        state_next = S_PUSH;
                    else if (!remote_mode_reg || count_reg < CW'(2))
                    begin
                        res_next     = latest_pose_reg;
                        blended_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        k_next     = '0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_PUSH:
            begin
                mem_we           = 1'b1;
                head_next        = push_head;
                count_next       = push_count + CW'(1);
                latest_pose_next = in_pose_reg;
                last_update_next = now_reg;
                state_next       = S_PRUNE_RD;
            end
            S_PRUNE_RD:
            begin
                time_raddr = head_reg;
                state_next = S_PRUNE_CMP;
            end
            S_PRUNE_CMP:
            begin
                // The newest entry has age zero and always stays.
                if (count_reg != '0 &&
                    $signed(now_age) > $signed({16'd0, history_window_reg}))
                begin
                    head_next  = slot_of(head_reg, IW'(1));
                    count_next = count_reg - CW'(1);
                    state_next = S_PRUNE_RD;
                end
                else
                    state_next = S_IDLE;
            end
            S_SCAN_RD:
            begin
                time_raddr = cur_slot;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                prev_t_next    = time_q;
                prev_slot_next = cur_slot;
                k_next         = k_reg + IW'(1);
                state_next     = S_SCAN_RD;
                if (k_reg == '0)
                    t0_next = time_q;
                else
                begin
                    if (k_reg == IW'(1))
                        t1_next = time_q;
                    if ($signed(prev_t_reg - render_reg) <= 0 &&
                        $signed(time_q - render_reg) >= 0)
                    begin
                        older_next   = prev_slot_reg;
                        newer_next   = cur_slot;
                        t_old_next   = prev_t_reg;
                        t_new_next   = time_q;
                        blended_next = 1'b1;
                        state_next   = S_FRAC;
                    end
                    else if ({1'b0, k_reg} == (count_reg - CW'(1)))
                    begin
                        if ($signed(time_q - render_reg) < 0)
                        begin
                            // Render time past the newest: return the newest as is.
                            older_next   = cur_slot;
                            newer_next   = cur_slot;
                            t_old_next   = time_q;
                            t_new_next   = time_q;
                            blended_next = 1'b0;
                        end
                        else
                        begin
                            older_next   = head_reg;
                            newer_next   = slot_of(head_reg, IW'(1));
                            t_old_next   = t0_reg;
                            t_new_next   = (k_reg == IW'(1)) ? time_q : t1_reg;
                            blended_next = 1'b1;
                        end
                        state_next = S_FRAC;
                    end
                end
            end
            S_FRAC:
            begin
                frac_next    = '0;
                rem_next     = el;
                div_cnt_next = '0;
                state_next   = S_POSE_OLD;
                if ($signed(span) > 0 && $signed(el) > 0)
                begin
                    if ($signed(el) >= $signed(span))
                        frac_next = FRAC_ONE;
                    else
                        state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit a cycle.
                if (rem_dbl >= {1'b0, span})
                begin
                    rem_next  = 32'(rem_dbl - {1'b0, span});
                    frac_next = {1'b0, frac_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_dbl[31:0];
                    frac_next = {1'b0, frac_reg[14:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == DIV_LAST)
                    state_next = S_POSE_OLD;
            end
            S_POSE_OLD:
            begin
                pose_raddr = older_reg;
                state_next = S_POSE_NEW;
            end
            S_POSE_NEW:
            begin
                pose_raddr    = newer_reg;
                pose_old_next = pose_q;
                state_next    = S_POSE_GET;
            end
            S_POSE_GET:
            begin
                pose_new_next = pose_q;
                j_next        = '0;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = 51'(diff_c * $signed({1'b0, frac_reg}));
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // Arithmetic shift gives the floor of the product over 2^16.
                res_next[32*j_reg +: 32] = old_c + prod_hi;
                j_next = j_reg + 3'd1;
                if (j_reg == COORD_LAST)
                    state_next = S_OUT;
                else
                    state_next = S_MUL;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = {blended_reg, stale_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (m_tvalid_reg && m_tready && state_reg != S_OUT)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            k_reg           <= '0;
            div_cnt_reg     <= '0;
            j_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
            latest_pose_reg <= '0;
            last_update_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            k_reg           <= k_next;
            div_cnt_reg     <= div_cnt_next;
            j_reg           <= j_next;
            m_tvalid_reg    <= m_tvalid_next;
            latest_pose_reg <= latest_pose_next;
            last_update_reg <= last_update_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg       <= now_next;
        in_pose_reg   <= in_pose_next;
        render_reg    <= render_next;
        stale_reg     <= stale_next;
        blended_reg   <= blended_next;
        prev_t_reg    <= prev_t_next;
        t0_reg        <= t0_next;
        t1_reg        <= t1_next;
        t_old_reg     <= t_old_next;
        t_new_reg     <= t_new_next;
        prev_slot_reg <= prev_slot_next;
        older_reg     <= older_next;
        newer_reg     <= newer_next;
        rem_reg       <= rem_next;
        frac_reg      <= frac_next;
        pose_old_reg  <= pose_old_next;
        pose_new_reg  <= pose_new_next;
        prod_reg      <= prod_next;
        res_reg       <= res_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    `SIB_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    `SIB_ASSERT(a_head_bound, {1'b0, head_reg} < (IW+1)'(RING_DEPTH))
    `SIB_ASSERT_NEXT(a_push_start, s_fire && s_tuser[0] == OP_PUSH, state_reg == S_PUSH)
    `SIB_ASSERT_NEXT(a_prune_keeps, state_reg == S_PUSH, count_reg != '0)
    `SIB_ASSERT(a_frac_bound, state_reg != S_MUL || frac_reg <= FRAC_ONE)

endmodule

### tb/snapshot_interpolation_buffer_top_tb.sv
// Self-checking bench for the snapshot interpolation buffer: random pushes and queries, scoreboard.
`timescale 1ns / 1ps
module snapshot_interpolation_buffer_top_tb;
    import sib_pkg::*;

    localparam int DEPTH = 64;
    localparam longint CYCLE_LIMIT = 2000000;

    // Pose of six signed Q16.16 coordinates plus the two result flags.
    typedef struct packed {
        logic [31:0] rz, ry, rx, pz, py, px;
    } pose_t;

    typedef struct {
        pose_t pose;
        logic  stale;
        logic  blended;
    } pose_result_t;

    // Scoreboard: it models the ring and keeps the queue of expected poses.
    class pose_scoreboard;
        logic [31:0] snap_time [DEPTH];
        pose_t       snap_pose [DEPTH];
        int          head, count;
        pose_t       latest;
        logic [31:0] last_update;
        logic        remote;
        logic [15:0] delay, stale_age, window;
        pose_result_t pending[$];
        int          errors;

        function new();
            head = 0; count = 0; latest = '0; last_update = 0;
            remote = 0; delay = RENDER_DELAY_RST; stale_age = STALE_AGE_RST;
            window = HISTORY_WINDOW_RST; errors = 0;
        endfunction

        function automatic longint age(logic [31:0] a, logic [31:0] b);
            logic signed [31:0] d;
            d = a - b;
            return longint'(d);
        endfunction

        function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, longint f);
            longint lo, p, q;
            lo = longint'($signed(a));
            p = (longint'($signed(b)) - lo) * f;
            if (p >= 0) q = p / 65536;
            else q = -((-p + 65535) / 65536);
            return 32'(lo + q);
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_REMOTE_MODE:    remote = v[0];
                REG_RENDER_DELAY:   delay = v[15:0];
                REG_STALE_AGE:      stale_age = v[15:0];
                REG_HISTORY_WINDOW: window = v[15:0];
            endcase
        endfunction

        // Notes an accepted word and queues the pose a query should give.
        function void note_word(logic op, logic [31:0] now, pose_t p);
            pose_result_t r;
            int i, a, b, older, newer, last;
            logic found;
            logic [31:0] render;
            longint span, el, f;
            pose_t po, pn;
            if (op == OP_PUSH) begin
                if (count >= DEPTH) begin
                    head = (head + 1) % DEPTH;
                    count = DEPTH - 1;
                end
                snap_time[(head + count) % DEPTH] = now;
                snap_pose[(head + count) % DEPTH] = p;
                count++;
                latest = p;
                last_update = now;
                while (count > 0 && age(now, snap_time[head]) > longint'(window)) begin
                    head = (head + 1) % DEPTH;
                    count--;
                end
                return;
            end
            r.stale = age(now, last_update) > longint'(stale_age);
            r.blended = 0;
            r.pose = latest;
            if (remote && count >= 2) begin
                render = now - 32'(delay);
                older = head; newer = (head + 1) % DEPTH; found = 0;
                for (i = 0; i + 1 < count && !found; i++) begin
                    a = (head + i) % DEPTH; b = (head + i + 1) % DEPTH;
                    if (age(snap_time[a], render) <= 0 && age(snap_time[b], render) >= 0) begin
                        older = a; newer = b; found = 1;
                    end
                end
                last = (head + count - 1) % DEPTH;
                if (!found && age(snap_time[last], render) < 0) begin
                    r.pose = snap_pose[last];
                end
                else begin
                    span = age(snap_time[newer], snap_time[older]);
                    el = age(render, snap_time[older]);
                    f = 0;
                    if (span > 0) begin
                        if (el <= 0) f = 0;
                        else if (el >= span) f = 65536;
                        else f = (el * 65536) / span;
                    end
                    po = snap_pose[older]; pn = snap_pose[newer];
                    r.pose.px = blend(po.px, pn.px, f);
                    r.pose.py = blend(po.py, pn.py, f);
                    r.pose.pz = blend(po.pz, pn.pz, f);
                    r.pose.rx = blend(po.rx, pn.rx, f);
                    r.pose.ry = blend(po.ry, pn.ry, f);
                    r.pose.rz = blend(po.rz, pn.rz, f);
                    r.blended = 1;
                end
            end
            pending = {pending, r};
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_pose(logic [191:0] data, logic [1:0] flags);
            pose_result_t r;
            pose_t got;
            if (pending.size() == 0) begin
                $error("pose result with no query waiting");
                errors++;
                return;
            end
            r = pending.pop_front();
            got = data;
            check_field("out_pos_x", r.pose.px, got.px);
            check_field("out_pos_y", r.pose.py, got.py);
            check_field("out_pos_z", r.pose.pz, got.pz);
            check_field("out_rot_x", r.pose.rx, got.rx);
            check_field("out_rot_y", r.pose.ry, got.ry);
            check_field("out_rot_z", r.pose.rz, got.rz);
            check_field("stale", 32'(r.stale), 32'(flags[0]));
            check_field("blended", 32'(r.blended), 32'(flags[1]));
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [223:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [191:0] m_tdata;
    logic [1:0] m_tuser;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pose_scoreboard board = new();
    longint cycles = 0;
    logic hold_off = 0;     // A long receiver stall, raised by the stimulus.
    logic stim_done = 0;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    snapshot_interpolation_buffer_top #(.RING_DEPTH(DEPTH)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // The run is cut off here if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[snapshot_interpolation_buffer_top] ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random stalls, plus the long hold-off; every accepted word is checked.
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_pose(m_tdata, m_tuser);
            if (hold_off) begin
                m_tready <= 0;
                repeat (3000) @(posedge clk);
                hold_off <= 0;
            end
            else begin
                n = gap_len();
                if (n == 0 || stim_done)
                    m_tready <= 1;
                else begin
                    m_tready <= 0;
                    repeat (n) @(posedge clk);
                    m_tready <= 1;
                end
            end
        end
    end

    // Writes one register with an APB setup phase and an access phase.
    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    // Offers one word and waits for the block to take it.
    task automatic send_word(logic op, logic [31:0] now, pose_t p);
        int n;
        n = gap_len();
        repeat (n) @(posedge clk);
        if (n == 0) @(posedge clk);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {p, now};
        do @(posedge clk); while (!s_tready);
        board.note_word(op, now, p);
        s_tvalid <= 0;
    endtask

    function automatic pose_t rand_pose();
        pose_t p;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 3) == 0) p = p >>> $urandom_range(8, 28);
        return p;
    endfunction

    // Waits until every query has been answered, then lets the block settle.
    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [31:0] t;
        int phase, k, burst;
        pose_t p;
        repeat (12) @(posedge clk);
        rst_n <= 1;

        // Directed part: queries with an empty ring, extremes, local and remote modes.
        t = 32'd5000;
        send_word(OP_QUERY, 32'd0, '0);
        send_word(OP_QUERY, 32'hFFFF_FFFF, '0);
        send_word(OP_PUSH, t, {6{32'h8000_0000}});
        send_word(OP_QUERY, t + 32'd2000, '0);
        drain();
        write_reg(REG_REMOTE_MODE, 32'd1);
        send_word(OP_QUERY, t, '0);
        send_word(OP_PUSH, t + 32'd100, {6{32'h7FFF_FFFF}});
        send_word(OP_QUERY, t + 32'd150, '0);
        send_word(OP_QUERY, t + 32'd190, '0);
        // Render time past the newest entry, then before all entries.
        send_word(OP_QUERY, t + 32'd900, '0);
        send_word(OP_QUERY, t + 32'd50, '0);
        // Two entries with the same time, then time running backwards.
        send_word(OP_PUSH, t + 32'd100, {6{32'h0001_0000}});
        send_word(OP_QUERY, t + 32'd200, '0);
        send_word(OP_PUSH, t + 32'd60, {6{32'hFFFF_0000}});
        send_word(OP_QUERY, t + 32'd170, '0);
        // Wrap of the time counter, and pushes far away from the older entries.
        send_word(OP_PUSH, 32'hFFFF_FFF0, rand_pose());
        send_word(OP_PUSH, 32'h0000_0010, rand_pose());
        send_word(OP_QUERY, 32'h0000_0070, '0);
        drain();

        // Random phases, each with its own register setting.
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_RENDER_DELAY, 32'd0); write_reg(REG_STALE_AGE, 32'd0);
                    write_reg(REG_HISTORY_WINDOW, 32'd1);
                end
                1: begin
                    write_reg(REG_RENDER_DELAY, 32'd65535);
                    write_reg(REG_STALE_AGE, 32'd65535);
                    write_reg(REG_HISTORY_WINDOW, 32'd65535);
                end
                2: write_reg(REG_HISTORY_WINDOW, 32'd0);
                3: write_reg(REG_REMOTE_MODE, 32'd0);
                default: begin
                    write_reg(REG_REMOTE_MODE, phase == 7 ? 32'd0 : {$urandom} | 32'd1);
                    write_reg(REG_RENDER_DELAY, $urandom_range(0, 400));
                    write_reg(REG_STALE_AGE, $urandom_range(0, 800));
                    write_reg(REG_HISTORY_WINDOW, $urandom_range(200, 3000));
                end
            endcase
            if (phase == 5) hold_off <= 1;
            t = $urandom;
            for (k = 0; k < 110; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    t = $urandom;
                    send_word(1'($urandom_range(0, 1)), t, rand_pose());
                end
                else if ($urandom_range(0, 2) != 0) begin
                    t = t + $urandom_range(0, 60);
                    send_word(OP_PUSH, t, rand_pose());
                end
                else begin
                    p = rand_pose();
                    send_word(OP_QUERY, t + $urandom_range(0, 500) - 32'd100, p);
                end
                // A steady burst of pushes fills the ring so it wraps.
                if (phase == 1 && k == 10)
                    for (burst = 0; burst < 80; burst++) begin
                        t = t + 32'd7;
                        send_word(OP_PUSH, t, rand_pose());
                    end
            end
            drain();
        end

        stim_done <= 1;
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[snapshot_interpolation_buffer_top] OK");
        else
            $display("[snapshot_interpolation_buffer_top] ERROR");
        $finish;
    end
endmodule
